/* design/lzw_code_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// LZW code decoder assertion macros
// Shared concurrent assertion forms for the decoder top level. Defining
// NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef LZW_CODE_DECODER_TOP_ASSERT_SVH
`define LZW_CODE_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge out of reset.
`define LZWD_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lzw_code_decoder: invariant violated");

// A condition that implies another in the same cycle.
`define LZWD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzw_code_decoder: implication violated");

`else

`define LZWD_ASSERT_HOLDS(label, clk, rst, cond)
`define LZWD_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

/* design/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// LZW code decoder package
// Widths, codes, channel structs and small helper functions shared by the
// decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

   // Dictionary geometry.
   localparam int MAX_CODE_BITS = 12;
   localparam int CODE_W        = MAX_CODE_BITS;
   localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
   localparam int COUNT_W       = MAX_CODE_BITS + 1;
   localparam int BYTE_W        = 8;
   localparam int SIZE_W        = 4;
   localparam int CSR_INDEX_W   = 2;

   // Register reset values and limits.
   localparam logic [SIZE_W-1:0] MIN_CODE_SIZE_RESET = 4'd8;
   localparam logic [SIZE_W-1:0] MAX_CODE_SIZE_RESET = 4'd12;
   localparam logic [SIZE_W-1:0] MIN_ROOT_BITS       = 4'd2;
   localparam logic [SIZE_W-1:0] MAX_ROOT_BITS       = 4'd8;
   localparam logic [SIZE_W-1:0] CODE_BITS_LIMIT     = SIZE_W'(MAX_CODE_BITS);

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CODE_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CODE_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EARLY_CHANGE  = 2'd2;

   // Item operations.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_CLEARED = 3'd1,
      STATUS_END     = 3'd2,
      STATUS_BEYOND  = 3'd3,
      STATUS_FULL    = 3'd4,
      STATUS_BUSY    = 3'd5
   } status_type;

   typedef struct packed {
      logic              operation;
      logic [CODE_W-1:0] code;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SIZE_W-1:0] code_width;
      logic [BYTE_W-1:0] data_byte;
      logic              byte_valid;
      logic              last_of_string;
   } rsp_type;

   // One write into the string buffer.
   typedef struct packed {
      logic              we;
      logic [CODE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } buf_write_type;

   // Start of a prefix chain walk.
   typedef struct packed {
      logic              start;
      logic [CODE_W-1:0] code;
      logic              reserve_first;
   } walk_cmd_type;

   // End of a prefix chain walk.
   typedef struct packed {
      logic               done;
      logic [BYTE_W-1:0]  first_byte;
      logic [COUNT_W-1:0] length;
   } walk_result_type;

   // Root symbol bits, saturated to the legal range.
   function automatic logic [SIZE_W-1:0] eff_min(input logic [SIZE_W-1:0] m);
      logic [SIZE_W-1:0] r;
      r = m;
      if (m < MIN_ROOT_BITS) begin
         r = MIN_ROOT_BITS;
      end else if (m > MAX_ROOT_BITS) begin
         r = MAX_ROOT_BITS;
      end
      return r;
   endfunction

   // Largest code width, saturated between root bits plus one and the limit.
   function automatic logic [SIZE_W-1:0] eff_max(input logic [SIZE_W-1:0] m,
                                                 input logic [SIZE_W-1:0] mx);
      logic [SIZE_W-1:0] lo;
      logic [SIZE_W-1:0] r;
      lo = eff_min(m) + SIZE_W'(1);
      r  = mx;
      if (r < lo) begin
         r = lo;
      end
      if (r > CODE_BITS_LIMIT) begin
         r = CODE_BITS_LIMIT;
      end
      return r;
   endfunction

   // Clear code for a given number of root bits.
   function automatic logic [COUNT_W-1:0] clear_code(input logic [SIZE_W-1:0] root_bits);
      return COUNT_W'(1) << root_bits;
   endfunction

endpackage

`default_nettype wire

/* design/lzwd_ram.sv */
// ----------------------------------------------------------------------------
// LZW decoder generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ram
   import lzwd_pkg::*;
#(
   parameter  int WIDTH  = BYTE_W,
   parameter  int DEPTH  = TABLE_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* design/lzwd_chain_walker.sv */
// ----------------------------------------------------------------------------
// LZW decoder prefix chain walker
// Follows a code's prefix chain one dictionary entry per cycle and writes the
// string into the buffer last byte first. Reports the root byte and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzwd_chain_walker
   import lzwd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire walk_cmd_type       cmd,
   input  wire logic [COUNT_W-1:0] clear_code_value,
   input  wire logic [CODE_W-1:0]  prefix_rd,
   input  wire logic [BYTE_W-1:0]  suffix_rd,
   output logic      [CODE_W-1:0]  rd_addr,
   output buf_write_type           buf_wr,
   output walk_result_type         result
);

   typedef enum logic {
      WK_IDLE,
      WK_STEP
   } walk_state_type;

   walk_state_type     state_ff, state_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [COUNT_W-1:0] pos_ff, pos_in;
   logic               done_ff, done_in;
   logic [BYTE_W-1:0]  first_ff, first_in;
   logic [COUNT_W-1:0] length_ff, length_in;
   logic               interior;

   // A code at or above the clear code still has a prefix to follow.
   assign interior = {1'b0, code_ff} >= clear_code_value;

   // One chain step per cycle; the dictionary read for the next code is
   // issued in the same cycle so its data is ready for the following step.
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      pos_in    = pos_ff;
      done_in   = 1'b0;
      first_in  = first_ff;
      length_in = length_ff;
      buf_wr    = '0;
      unique case (state_ff)
         WK_IDLE: begin
            if (cmd.start) begin
               code_in  = cmd.code;
               pos_in   = cmd.reserve_first ? COUNT_W'(1) : '0;
               state_in = WK_STEP;
            end
         end
         WK_STEP: begin
            buf_wr.we   = 1'b1;
            buf_wr.addr = pos_ff[CODE_W-1:0];
            if (interior) begin
               buf_wr.data = suffix_rd;
               code_in     = prefix_rd;
               pos_in      = pos_ff + COUNT_W'(1);
            end else begin
               buf_wr.data = code_ff[BYTE_W-1:0];
               first_in    = code_ff[BYTE_W-1:0];
               length_in   = pos_ff + COUNT_W'(1);
               done_in     = 1'b1;
               state_in    = WK_IDLE;
            end
         end
      endcase
   end

   assign rd_addr           = code_in;
   assign result.done       = done_ff;
   assign result.first_byte = first_ff;
   assign result.length     = length_ff;

   // State and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      code_ff   <= code_in;
      pos_ff    <= pos_in;
      first_ff  <= first_in;
      length_ff <= length_in;
   end

endmodule

`default_nettype wire

/* design/lzw_code_decoder_top.sv */
// ----------------------------------------------------------------------------
// LZW code decoder
// Variable-width LZW decoder with clear and end codes. A push item hands in one
// code already unpacked at the width reported by the previous result; a pull
// item returns the decoded string one byte at a time, first to last. A push
// that only reports a status (busy, clear, end, beyond table, table full, or
// the first root code after a clear) gives its result in the cycle after it is
// taken. A push that grows the dictionary walks the code's prefix chain one
// entry per cycle through the registered-read prefix memory. When the code
// equals the next free entry, only the previous string is walked. A pull
// reads the buffer through its registered read port before it answers; an
// empty pull answers without a buffer read. The dictionary and the string
// buffer are not cleared after reset and need no clearing pass; writing
// min_code_size or max_code_size resets the table as a clear code does.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lzw_code_decoder_top_assert.svh"

module lzw_code_decoder_top
   import lzwd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PULL
   } ctrl_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] next_free;
      logic [SIZE_W-1:0]  width;
      logic [COUNT_W-1:0] limit;
      logic [CODE_W-1:0]  prev_code;
      logic               prev_valid;
   } table_type;

   // Table state right after a clear.
   function automatic table_type table_reset(input logic [SIZE_W-1:0] root_bits);
      table_type t;
      t.next_free  = clear_code(root_bits) + COUNT_W'(2);
      t.width      = root_bits + SIZE_W'(1);
      t.limit      = COUNT_W'(1) << t.width;
      t.prev_code  = '0;
      t.prev_valid = 1'b0;
      return t;
   endfunction

   ctrl_state_type     state_ff, state_in;
   logic [SIZE_W-1:0]  min_ff, min_in;
   logic [SIZE_W-1:0]  max_ff, max_in;
   logic               early_ff, early_in;
   table_type          table_ff, table_in;
   logic [COUNT_W-1:0] pending_ff, pending_in;
   logic               self_ref_ff, self_ref_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [SIZE_W-1:0]  eff_min_bits;
   logic [SIZE_W-1:0]  eff_max_bits;
   logic [COUNT_W-1:0] clr;
   logic [COUNT_W-1:0] code_ext;
   logic [COUNT_W-1:0] next_free_inc;
   logic [COUNT_W-1:0] pending_dec;
   logic               req_accept;
   logic               rsp_load;
   status_type         rsp_status;
   logic [BYTE_W-1:0]  rsp_byte;
   logic               rsp_byte_valid;
   logic               rsp_last;

   walk_cmd_type       walk_cmd;
   walk_result_type    walk_res;
   buf_write_type      walk_wr;
   buf_write_type      top_wr;
   buf_write_type      buf_wr;
   logic               dict_we;
   logic [CODE_W-1:0]  walk_addr;
   logic [CODE_W-1:0]  prefix_rd;
   logic [BYTE_W-1:0]  suffix_rd;
   logic [BYTE_W-1:0]  buf_rd;

   assign eff_min_bits  = eff_min(min_ff);
   assign eff_max_bits  = eff_max(min_ff, max_ff);
   assign clr           = clear_code(eff_min_bits);
   assign code_ext      = {1'b0, req_data.code};
   assign next_free_inc = table_ff.next_free + COUNT_W'(1);
   assign pending_dec   = pending_ff - COUNT_W'(1);

   // Handshakes: one item at a time, and never over a result still waiting.
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Item sequencing, table updates and register writes.
   always_comb begin
      state_in       = state_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      early_in       = early_ff;
      table_in       = table_ff;
      pending_in     = pending_ff;
      self_ref_in    = self_ref_ff;
      code_in        = code_ff;
      walk_cmd       = '0;
      top_wr         = '0;
      dict_we        = 1'b0;
      rsp_load       = 1'b0;
      rsp_status     = STATUS_OK;
      rsp_byte       = '0;
      rsp_byte_valid = 1'b0;
      rsp_last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.operation == OP_PUSH) begin
                  rsp_load = 1'b1;
                  priority if (pending_ff != '0) begin
                     rsp_status = STATUS_BUSY;
                  end else if (code_ext == clr + COUNT_W'(1)) begin
                     rsp_status = STATUS_END;
                  end else if (code_ext == clr) begin
                     rsp_status = STATUS_CLEARED;
                     table_in   = table_reset(eff_min_bits);
                  end else if (code_ext > table_ff.next_free) begin
                     rsp_status = STATUS_BEYOND;
                  end else if (!table_ff.prev_valid) begin
                     // First code after a clear must be a root symbol.
                     if (code_ext >= clr) begin
                        rsp_status = STATUS_BEYOND;
                     end else begin
                        top_wr.we           = 1'b1;
                        top_wr.addr         = '0;
                        top_wr.data         = req_data.code[BYTE_W-1:0];
                        pending_in          = COUNT_W'(1);
                        table_in.prev_code  = req_data.code;
                        table_in.prev_valid = 1'b1;
                     end
                  end else if (table_ff.next_free >= table_ff.limit) begin
                     rsp_status = STATUS_FULL;
                  end else begin
                     // A code equal to the next free entry spells the previous
                     // string plus its own first byte.
                     rsp_load               = 1'b0;
                     walk_cmd.start         = 1'b1;
                     walk_cmd.reserve_first = (code_ext == table_ff.next_free);
                     walk_cmd.code          = (code_ext == table_ff.next_free) ?
                                              table_ff.prev_code : req_data.code;
                     self_ref_in            = (code_ext == table_ff.next_free);
                     code_in                = req_data.code;
                     state_in               = ST_WALK;
                  end
               end else begin
                  if (pending_ff == '0) begin
                     rsp_load = 1'b1;
                  end else begin
                     state_in = ST_PULL;
                  end
               end
            end
         end
         ST_PULL: begin
            rsp_load       = 1'b1;
            rsp_byte       = buf_rd;
            rsp_byte_valid = 1'b1;
            rsp_last       = (pending_ff == COUNT_W'(1));
            pending_in     = pending_dec;
            state_in       = ST_IDLE;
         end
         ST_WALK: begin
            if (walk_res.done) begin
               // Finish the self-referencing string with its first byte.
               if (self_ref_ff) begin
                  top_wr.we   = 1'b1;
                  top_wr.addr = '0;
                  top_wr.data = walk_res.first_byte;
               end
               dict_we            = 1'b1;
               table_in.next_free = next_free_inc;
               if ((next_free_inc + COUNT_W'(early_ff)) >= table_ff.limit &&
                   table_ff.width < eff_max_bits) begin
                  table_in.width = table_ff.width + SIZE_W'(1);
                  table_in.limit = table_ff.limit << 1;
               end
               table_in.prev_code = code_ff;
               pending_in         = walk_res.length;
               rsp_load           = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must send register writes only while no item is in flight; the block itself does not enforce this.
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_CODE_SIZE: begin
               min_in   = csr_wdata;
               table_in = table_reset(eff_min(csr_wdata));
            end
            CSR_MAX_CODE_SIZE: begin
               max_in   = csr_wdata;
               table_in = table_reset(eff_min_bits);
            end
            CSR_EARLY_CHANGE: begin
               early_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      rsp_in.status         = rsp_status;
      rsp_in.code_width     = table_in.width;
      rsp_in.data_byte      = rsp_byte;
      rsp_in.byte_valid     = rsp_byte_valid;
      rsp_in.last_of_string = rsp_last;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_CODE_SIZE_RESET;
         max_ff       <= MAX_CODE_SIZE_RESET;
         early_ff     <= 1'b0;
         table_ff     <= table_reset(eff_min(MIN_CODE_SIZE_RESET));
         pending_ff   <= '0;
         self_ref_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         early_ff     <= early_in;
         table_ff     <= table_in;
         pending_ff   <= pending_in;
         self_ref_ff  <= self_ref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff <= code_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // The buffer write port serves the walker and the sequencer in turn.
   assign buf_wr = walk_wr.we ? walk_wr : top_wr;

   lzwd_chain_walker u_walker (
      .clock            (clock),
      .reset            (reset),
      .cmd              (walk_cmd),
      .clear_code_value (clr),
      .prefix_rd        (prefix_rd),
      .suffix_rd        (suffix_rd),
      .rd_addr          (walk_addr),
      .buf_wr           (walk_wr),
      .result           (walk_res)
   );

   // Dictionary: prefix code of each entry.
   lzwd_ram #(
      .WIDTH (CODE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (table_ff.next_free[CODE_W-1:0]),
      .wr_data (table_ff.prev_code),
      .rd_addr (walk_addr),
      .rd_data (prefix_rd)
   );

   // Dictionary: last byte of each entry.
   lzwd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_suffix_ram (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (table_ff.next_free[CODE_W-1:0]),
      .wr_data (walk_res.first_byte),
      .rd_addr (walk_addr),
      .rd_data (suffix_rd)
   );

   // Decoded string, stored last byte first; pulls read from the top down.
   lzwd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_string_ram (
      .clock   (clock),
      .wr_en   (buf_wr.we),
      .wr_addr (buf_wr.addr),
      .wr_data (buf_wr.data),
      .rd_addr (pending_dec[CODE_W-1:0]),
      .rd_data (buf_rd)
   );

   // The walker finishes only while the sequencer waits for it.
   `LZWD_ASSERT_IMPLIES(a_done_in_walk, clock, reset, walk_res.done, state_ff == ST_WALK)
   // The next free entry never passes the current width limit.
   `LZWD_ASSERT_HOLDS(a_entry_bound, clock, reset, table_ff.next_free <= table_ff.limit)
   // A new result never overwrites one that is still waiting.
   `LZWD_ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || !rsp_stall)
   // The walker and the sequencer never write the buffer in the same cycle.
   `LZWD_ASSERT_HOLDS(a_one_buf_writer, clock, reset, !(walk_wr.we && top_wr.we))

endmodule

`default_nettype wire

/* tb/tb_lzw_code_decoder_top.sv */
// ----------------------------------------------------------------------------
// LZW code decoder testbench
// Drives code and pull items into the decoder and checks every result against
// a cycle-free model of the dictionary, the code width and the string buffer.
// A planning copy of the model shapes well-formed code streams, and a checking
// copy predicts each result when its item is accepted. The run steps through
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lzw_code_decoder_top;
   import lzwd_pkg::*;

   localparam int PLAN             = 0;
   localparam int CHECK            = 1;
   localparam int TABLE_MASK       = TABLE_DEPTH - 1;
   localparam int ITEMS_PER_PHASE  = 150;
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int DRAIN_CYCLES     = 20;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]      csr_wdata = '0;

   // Items waiting to be sent and results waiting to arrive.
   req_type req_backlog [$];
   rsp_type rsp_due [$];
   rsp_type rsp_want;

   int sender_idle_pct   = 8;
   int receiver_idle_pct = 70;
   int fail_count        = 0;
   int idle_cycles;

   // Two copies of the decoder state: one plans stimulus, one checks results.
   logic [CODE_W-1:0] prefix_mem [2][TABLE_DEPTH];
   logic [BYTE_W-1:0] suffix_mem [2][TABLE_DEPTH];
   logic [BYTE_W-1:0] string_mem [2][TABLE_DEPTH];
   logic [SIZE_W-1:0] min_size_reg [2];
   logic [SIZE_W-1:0] max_size_reg [2];
   logic              early_reg [2];
   int                next_free [2];
   int                width_now [2];
   int                width_top [2];
   int                prior_code [2];
   logic              prior_ok [2];
   int                bytes_left [2];
   int                read_ptr [2];

   lzw_code_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Root symbol bits in use, clamped to 2..8.
   function automatic int root_bits(int u);
      int m;
      m = min_size_reg[u];
      if (m < 2) m = 2;
      if (m > 8) m = 8;
      return m;
   endfunction

   // Widest code allowed, clamped between root bits plus one and the maximum.
   function automatic int width_cap(int u);
      int m;
      int lo;
      m  = max_size_reg[u];
      lo = root_bits(u) + 1;
      if (m < lo) m = lo;
      if (m > MAX_CODE_BITS) m = MAX_CODE_BITS;
      return m;
   endfunction

   function automatic void restart_table(int u);
      next_free[u]  = (1 << root_bits(u)) + 2;
      width_now[u]  = root_bits(u) + 1;
      width_top[u]  = 1 << width_now[u];
      prior_code[u] = 0;
      prior_ok[u]   = 1'b0;
   endfunction

   function automatic void power_on(int u);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         prefix_mem[u][i] = '0;
         suffix_mem[u][i] = '0;
         string_mem[u][i] = '0;
      end
      min_size_reg[u] = MIN_CODE_SIZE_RESET;
      max_size_reg[u] = MAX_CODE_SIZE_RESET;
      early_reg[u]    = 1'b0;
      bytes_left[u]   = 0;
      read_ptr[u]     = 0;
      restart_table(u);
   endfunction

   // Size writes restart the table; the early change bit does not.
   function automatic void write_model_reg(int u, logic [CSR_INDEX_W-1:0] idx,
                                           logic [SIZE_W-1:0] val);
      case (idx)
         CSR_MIN_CODE_SIZE: begin
            min_size_reg[u] = val;
            restart_table(u);
         end
         CSR_MAX_CODE_SIZE: begin
            max_size_reg[u] = val;
            restart_table(u);
         end
         CSR_EARLY_CHANGE: begin
            early_reg[u] = val[0];
         end
         default: ;
      endcase
   endfunction

   // Number of bytes in the string of a code, following the prefix chain.
   function automatic int chain_length(int u, int c);
      int n;
      int clr;
      n   = 1;
      clr = 1 << root_bits(u);
      while (c >= clr && n < TABLE_DEPTH) begin
         c = prefix_mem[u][c & TABLE_MASK];
         n++;
      end
      return n;
   endfunction

   // First byte of the string of a code.
   function automatic logic [BYTE_W-1:0] chain_head(int u, int c);
      int n;
      int clr;
      n   = 0;
      clr = 1 << root_bits(u);
      while (c >= clr && n < TABLE_DEPTH) begin
         c = prefix_mem[u][c & TABLE_MASK];
         n++;
      end
      return BYTE_W'(c);
   endfunction

   function automatic status_type push_code(int u, int code);
      int clr;
      int len;
      int c;
      int i;
      clr = 1 << root_bits(u);
      if (bytes_left[u] > 0) return STATUS_BUSY;
      if (code == clr + 1) return STATUS_END;
      if (code == clr) begin
         restart_table(u);
         return STATUS_CLEARED;
      end
      if (code > next_free[u]) return STATUS_BEYOND;
      // The first code after a clear must be a root and adds no entry.
      if (!prior_ok[u]) begin
         if (code >= clr) return STATUS_BEYOND;
         string_mem[u][0] = BYTE_W'(code);
         bytes_left[u]    = 1;
         read_ptr[u]      = 0;
         prior_code[u]    = code;
         prior_ok[u]      = 1'b1;
         return STATUS_OK;
      end
      if (next_free[u] >= width_top[u]) return STATUS_FULL;

      // The new entry is the previous string plus the first byte of this one.
      // Writing the prefix first makes a code equal to the next free entry work.
      prefix_mem[u][next_free[u] & TABLE_MASK] = CODE_W'(prior_code[u]);
      suffix_mem[u][next_free[u] & TABLE_MASK] = chain_head(u, code);
      next_free[u]++;
      if (next_free[u] + int'(early_reg[u]) >= width_top[u] && width_now[u] < width_cap(u)) begin
         width_now[u]++;
         width_top[u] = 1 << width_now[u];
      end
      prior_code[u] = code;

      // Expand the string into the buffer, last byte first.
      len = chain_length(u, code);
      c   = code;
      i   = len;
      while (i > 0) begin
         i--;
         if (c >= clr) begin
            string_mem[u][i & TABLE_MASK] = suffix_mem[u][c & TABLE_MASK];
            c = prefix_mem[u][c & TABLE_MASK];
         end else begin
            string_mem[u][i & TABLE_MASK] = BYTE_W'(c);
         end
      end
      bytes_left[u] = len;
      read_ptr[u]   = 0;
      return STATUS_OK;
   endfunction

   // Expected result of one item, advancing the chosen copy of the state.
   function automatic rsp_type decode_item(int u, req_type item);
      rsp_type res;
      res = '0;
      if (item.operation == OP_PUSH) begin
         res.status = push_code(u, int'(item.code));
      end else begin
         res.status = STATUS_OK;
         if (bytes_left[u] > 0) begin
            res.data_byte      = string_mem[u][read_ptr[u] & TABLE_MASK];
            read_ptr[u]++;
            bytes_left[u]--;
            res.byte_valid     = 1'b1;
            res.last_of_string = (bytes_left[u] == 0);
         end
      end
      res.code_width = SIZE_W'(width_now[u]);
      return res;
   endfunction

   // Queue one item and return the result that the planning copy foresees.
   function automatic rsp_type queue_item(logic op, int code);
      req_type r;
      r.operation = op;
      r.code      = CODE_W'(code);
      req_backlog.push_back(r);
      return decode_item(PLAN, r);
   endfunction

   task automatic pull_pending();
      while (bytes_left[PLAN] > 0) begin
         void'(queue_item(OP_PULL, $urandom_range(0, TABLE_DEPTH - 1)));
      end
   endtask

   // Wait until every queued item has gone out and every result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [SIZE_W-1:0] val);
      wait_drained();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      write_model_reg(PLAN, idx, val);
      write_model_reg(CHECK, idx, val);
   endtask

   // Mostly well-formed code streams with their pulls, mixed with clears,
   // end codes, stray codes, busy pushes and empty pulls.
   task automatic random_phase(int target);
      int      done;
      int      pause_at;
      int      clr;
      int      r;
      int      k;
      int      code;
      logic    op;
      rsp_type res;
      done     = 0;
      pause_at = target / 2;
      while (done < target) begin
         // Hold the sender once per phase until the block has gone quiet.
         if (done >= pause_at) begin
            wait_drained();
            pause_at = target * 2;
         end
         clr  = 1 << root_bits(PLAN);
         op   = OP_PUSH;
         code = $urandom_range(0, TABLE_DEPTH - 1);
         if (bytes_left[PLAN] > 0) begin
            if ($urandom_range(0, 99) >= 5) op = OP_PULL;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               code = clr;
            end else if (r < 6) begin
               code = clr + 1;
            end else if (r < 10) begin
               code = $urandom_range(0, TABLE_DEPTH - 1);
            end else if (r < 13) begin
               op = OP_PULL;
            end else if (!prior_ok[PLAN]) begin
               code = $urandom_range(0, clr - 1);
            end else if (next_free[PLAN] >= width_top[PLAN] && $urandom_range(0, 3) != 0) begin
               code = clr;
            end else begin
               k = $urandom_range(0, 9);
               if (k < 3) begin
                  code = $urandom_range(0, clr - 1);
               end else if (k < 8 && next_free[PLAN] > clr + 2) begin
                  code = $urandom_range(clr + 2, next_free[PLAN] - 1);
               end else begin
                  code = next_free[PLAN];
               end
            end
         end
         res = queue_item(op, code);
         if (!(res.status == STATUS_BUSY || (op == OP_PULL && !res.byte_valid))) done++;
      end
   endtask

   task automatic run_phase(int mode, logic [SIZE_W-1:0] min_size,
                            logic [SIZE_W-1:0] max_size, logic early);
      wait_drained();
      case (mode)
         0: begin
            sender_idle_pct   = 8;
            receiver_idle_pct = 70;
         end
         1: begin
            sender_idle_pct   = 70;
            receiver_idle_pct = 8;
         end
         default: begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
      endcase
      write_reg(CSR_MIN_CODE_SIZE, min_size);
      write_reg(CSR_MAX_CODE_SIZE, max_size);
      write_reg(CSR_EARLY_CHANGE, SIZE_W'(early));
      random_phase(ITEMS_PER_PHASE);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      $display("ERROR: %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
   endtask

   // Sender: presents the next item when the channel is free, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rsp_due.push_back(decode_item(CHECK, req_data));
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               report_mismatch("result with no item outstanding, status", int'(rsp_data.status), -1);
            end else begin
               rsp_want = rsp_due.pop_front();
               if (rsp_data.status != rsp_want.status)
                  report_mismatch("status", int'(rsp_data.status), int'(rsp_want.status));
               if (rsp_data.code_width != rsp_want.code_width)
                  report_mismatch("code_width", rsp_data.code_width, rsp_want.code_width);
               if (rsp_data.data_byte != rsp_want.data_byte)
                  report_mismatch("data_byte", rsp_data.data_byte, rsp_want.data_byte);
               if (rsp_data.byte_valid != rsp_want.byte_valid)
                  report_mismatch("byte_valid", rsp_data.byte_valid, rsp_want.byte_valid);
               if (rsp_data.last_of_string != rsp_want.last_of_string)
                  report_mismatch("last_of_string", rsp_data.last_of_string,
                                  rsp_want.last_of_string);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // Watchdog: ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int clr;
      power_on(PLAN);
      power_on(CHECK);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: 8 root bits, clear code 256.
      clr = 1 << root_bits(PLAN);
      void'(queue_item(OP_PULL, TABLE_DEPTH - 1));
      void'(queue_item(OP_PUSH, clr + 1));
      void'(queue_item(OP_PUSH, TABLE_DEPTH - 1));
      void'(queue_item(OP_PUSH, clr + 2));
      void'(queue_item(OP_PUSH, 65));
      void'(queue_item(OP_PUSH, 66));
      void'(queue_item(OP_PULL, 0));
      void'(queue_item(OP_PULL, 0));
      void'(queue_item(OP_PUSH, 66));
      void'(queue_item(OP_PUSH, 0));
      pull_pending();
      // A code above the next free entry.
      void'(queue_item(OP_PUSH, clr + 4));
      pull_pending();
      void'(queue_item(OP_PULL, TABLE_DEPTH - 1));
      void'(queue_item(OP_PUSH, clr + 2));
      pull_pending();
      void'(queue_item(OP_PUSH, clr));
      void'(queue_item(OP_PUSH, 255));
      pull_pending();
      void'(queue_item(OP_PUSH, 0));
      pull_pending();
      void'(queue_item(OP_PUSH, clr + 1));

      // Random phases over several settings, clamped values among them.
      run_phase(0, 4'd2, 4'd3, 1'b0);
      run_phase(0, 4'd8, 4'd12, 1'b1);
      run_phase(1, 4'd0, 4'd15, 1'b1);
      run_phase(1, 4'd2, 4'd4, 1'b0);
      run_phase(2, 4'd15, 4'd0, 1'b0);
      run_phase(2, 4'd3, 4'd6, 1'b1);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
